### sv/swls_pkg.sv
// swls_pkg: shared types and constants for the sliding window latency statistics core
// no dependencies; imported by sliding_window_latency_stats_core

package swls_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 16;
    localparam int unsigned LAT_W            = 16;
    localparam int unsigned FILL_W           = 5;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

### sv/sliding_window_latency_stats_core.sv
// add transaction: reads the old sample, updates the window, scans the n slots held after the add,
// then runs a restoring divider over the sum (16 deep: 20-bit sum); one ram read per scanned slot
// and one quotient bit per cycle. clear transaction: goes straight to the result stage.
// one transaction at a time; input ready again once the result sits in the output register.
// synchronous active-low reset empties the window (count, position, sum) and drops o_out_valid;
// sample ram contents are not reset

module sliding_window_latency_stats_core
    import swls_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [LAT_W-1:0]  i_latency,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [LAT_W-1:0]  o_min_latency,
    output logic [LAT_W-1:0]  o_max_latency,
    output logic [LAT_W-1:0]  o_mean_latency,
    output logic [LAT_W-1:0]  o_jitter,
    output logic [FILL_W-1:0] o_fill_count
);

    // derived widths
    localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUM_W  = LAT_W + PTR_W;     // holds WINDOW_DEPTH * 65535
    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [STEP_W-1:0] STEPS    = STEP_W'(SUM_W);

    // sample store, one read and one write port, registered read data
    logic [LAT_W-1:0] mem [WINDOW_DEPTH];
    logic [LAT_W-1:0] r_rd_data;
    logic [PTR_W-1:0] w_rd_addr;
    logic             w_wr_en;

    // sequencer
    t_state r_state, n_state;

    // window state
    logic [PTR_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;
    logic [LAT_W-1:0] r_sample;

    // min / max scan
    logic [PTR_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic [LAT_W-1:0] r_lo;
    logic [LAT_W-1:0] r_hi;
    logic             w_scan_last;

    // restoring divider: dividend shifts out of r_quo as quotient bits shift in
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    logic w_full;
    logic w_in_acc;
    logic w_fin_go;

    assign w_full      = (r_count == CNT_FULL);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_fin_go    = (r_state == ST_FIN) && (!o_out_valid || i_out_ready);
    assign w_scan_last = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_count});
    assign w_diff  = w_trial - {1'b0, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == MODE_CLEAR) ? ST_FIN : ST_RD_OLD;
                end
            end
            ST_RD_OLD: n_state = ST_UPD;
            ST_UPD:    n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STEP_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_wr_en    = 1'b0;
        w_rd_addr  = r_pos;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_UPD:  w_wr_en    = 1'b1;
            ST_SCAN: w_rd_addr  = r_idx;
            default: ;
        endcase
    end

    // sample ram
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_pos] <= r_sample;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_cmp_vld   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (w_in_acc && i_mode == MODE_CLEAR) begin
                r_pos   <= '0;
                r_count <= '0;
                r_sum   <= '0;
            end
            if (r_state == ST_UPD) begin
                // full window: oldest sample (read last cycle) leaves the sum
                if (w_full) begin
                    r_sum <= r_sum - SUM_W'(r_rd_data) + SUM_W'(r_sample);
                end else begin
                    r_sum   <= r_sum + SUM_W'(r_sample);
                    r_count <= r_count + CNT_W'(1);
                end
                r_pos <= (r_pos == PTR_LAST) ? '0 : r_pos + PTR_W'(1);
            end
            if (w_fin_go) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_latency;
        end
        if (r_state == ST_UPD) begin
            r_idx <= '0;
            r_lo  <= '1;
            r_hi  <= '0;
        end
        if (r_state == ST_SCAN) begin
            r_idx <= r_idx + PTR_W'(1);
        end
        // compare uses the registered read data, in the cycle after its read address
        if (r_cmp_vld) begin
            if (r_rd_data < r_lo) begin
                r_lo <= r_rd_data;
            end
            if (r_rd_data > r_hi) begin
                r_hi <= r_rd_data;
            end
        end
        if (r_state == ST_DRAIN) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_step <= STEPS;
        end
        if (r_state == ST_DIV) begin
            r_quo  <= {r_quo[SUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_step <= r_step - STEP_W'(1);
        end
        if (w_fin_go) begin
            if (r_count == '0) begin
                o_min_latency  <= '0;
                o_max_latency  <= '0;
                o_mean_latency <= '0;
                o_jitter       <= '0;
            end else begin
                o_min_latency  <= r_lo;
                o_max_latency  <= r_hi;
                o_mean_latency <= r_quo[LAT_W-1:0];
                o_jitter       <= r_hi - r_lo;
            end
            o_fill_count <= FILL_W'(r_count);
        end
    end

endmodule

### verif/sliding_window_latency_stats_core_tb.sv
`timescale 1ns / 100ps
// sliding_window_latency_stats_core_tb: self-checking bench for the windowed latency stats core
// depends on swls_pkg and sliding_window_latency_stats_core; a directed table, then random traffic,
// every result compared against hand-typed values or an in-bench model of the sample window

module sliding_window_latency_stats_core_tb
    import swls_pkg::*;
();

    localparam int unsigned DEPTH            = WINDOW_DEPTH_DEF;
    localparam int unsigned DIRECTED_ROWS    = 24;
    localparam int unsigned RANDOM_ITEMS     = 430;
    localparam int unsigned LONG_HOLD_AT     = 150;
    localparam int unsigned SENDER_PAUSE_AT  = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    // settling time after the last owed result, longer than the worst add transaction
    localparam int unsigned SETTLE_CYCLES    = 60;

    typedef struct packed {
        logic [LAT_W-1:0]  min_lat;
        logic [LAT_W-1:0]  max_lat;
        logic [LAT_W-1:0]  mean_lat;
        logic [LAT_W-1:0]  jitter;
        logic [FILL_W-1:0] fill;
    } t_lat_stats;

    // one directed transaction; known rows carry their result typed in by hand
    typedef struct packed {
        logic             mode;
        logic [LAT_W-1:0] latency;
        bit               known;
        t_lat_stats       stats;
    } t_stim_row;

    // how the random part draws its samples, one profile per block of transactions
    typedef enum int unsigned {
        LAT_ANY,
        LAT_TOP,
        LAT_LOW,
        LAT_EDGE,
        LAT_ONEHOT
    } t_lat_profile;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_mode      = MODE_ADD;
    logic [LAT_W-1:0]  i_latency   = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [LAT_W-1:0]  o_min_latency;
    logic [LAT_W-1:0]  o_max_latency;
    logic [LAT_W-1:0]  o_mean_latency;
    logic [LAT_W-1:0]  o_jitter;
    logic [FILL_W-1:0] o_fill_count;

    // bench copy of the window state
    logic [LAT_W-1:0] model_window [DEPTH] = '{default: '0};
    int unsigned      model_pos   = 0;
    int unsigned      model_count = 0;
    int unsigned      model_sum   = 0;

    // statistics still owed by the core, oldest first
    t_lat_stats pending_stats [$];
    int unsigned mismatch_count = 0;

    // burst: no idling on either side; long_hold_req: ask the sink for one long stall
    bit burst         = 1'b0;
    bit long_hold_req = 1'b0;

    // directed table: empty window, extremes, filling to depth, eviction, repeated clears
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{MODE_CLEAR, 16'hA5A5, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0}},
        '{MODE_ADD,   16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 5'd1}},
        '{MODE_ADD,   16'h0000, 1'b1, '{16'h0000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 5'd2}},
        '{MODE_ADD,   16'h0001, 1'b0, '0},
        '{MODE_ADD,   16'h8000, 1'b0, '0},
        '{MODE_ADD,   16'h7FFF, 1'b0, '0},
        '{MODE_ADD,   16'h1234, 1'b0, '0},
        '{MODE_ADD,   16'hFFFE, 1'b0, '0},
        '{MODE_ADD,   16'h0002, 1'b0, '0},
        '{MODE_ADD,   16'h5555, 1'b0, '0},
        '{MODE_ADD,   16'hAAAA, 1'b0, '0},
        '{MODE_ADD,   16'h00FF, 1'b0, '0},
        '{MODE_ADD,   16'hFF00, 1'b0, '0},
        '{MODE_ADD,   16'h4000, 1'b0, '0},
        '{MODE_ADD,   16'hC000, 1'b0, '0},
        '{MODE_ADD,   16'h0100, 1'b0, '0},
        '{MODE_ADD,   16'h0010, 1'b0, '0},
        '{MODE_ADD,   16'h0000, 1'b0, '0},
        '{MODE_ADD,   16'hFFFF, 1'b0, '0},
        '{MODE_ADD,   16'h3333, 1'b0, '0},
        '{MODE_CLEAR, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0}},
        '{MODE_CLEAR, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0}},
        '{MODE_ADD,   16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd1}},
        '{MODE_ADD,   16'hFFFF, 1'b0, '0}
    };

    sliding_window_latency_stats_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_latency      (i_latency),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_min_latency  (o_min_latency),
        .o_max_latency  (o_max_latency),
        .o_mean_latency (o_mean_latency),
        .o_jitter       (o_jitter),
        .o_fill_count   (o_fill_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one transaction to the bench window and returns the statistics it should report;
    // held samples are always slots 0 .. count-1 since the position restarts at 0 on a clear
    function automatic t_lat_stats apply_window_txn(input logic mode,
                                                    input logic [LAT_W-1:0] lat);
        t_lat_stats  s;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        s = '0;
        if (mode == MODE_CLEAR) begin
            // stored samples stay put, they just stop counting
            model_count = 0;
            model_pos   = 0;
            model_sum   = 0;
        end else begin
            // a full window drops the oldest sample, which sits at the write position
            if (model_count >= DEPTH) begin
                model_sum -= model_window[model_pos];
            end else begin
                model_count++;
            end
            model_window[model_pos] = lat;
            model_sum += lat;
            model_pos = (model_pos + 1) % DEPTH;
        end
        // empty window reports all zeros
        if (model_count != 0) begin
            lo = 16'hFFFF;
            hi = 0;
            for (k = 0; k < model_count; k++) begin
                if (model_window[k] < lo) begin
                    lo = model_window[k];
                end
                if (model_window[k] > hi) begin
                    hi = model_window[k];
                end
            end
            s.min_lat  = LAT_W'(lo);
            s.max_lat  = LAT_W'(hi);
            s.mean_lat = LAT_W'(model_sum / model_count);
            s.jitter   = LAT_W'(hi - lo);
        end
        s.fill = FILL_W'(model_count);
        return s;
    endfunction

    // idle length for either side: mostly none, some short, a few long
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [LAT_W-1:0] draw_latency(input t_lat_profile profile);
        case (profile)
            LAT_TOP:    return ($urandom_range(3) == 0) ? 16'hFFFE : 16'hFFFF;
            LAT_LOW:    return LAT_W'($urandom_range(15));
            LAT_EDGE:   return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            LAT_ONEHOT: return 16'h0001 << $urandom_range(15);
            default:    return LAT_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // offers one transaction after a random gap and books its statistics once accepted
    task automatic send_window_txn(input logic mode, input logic [LAT_W-1:0] lat,
                                   input bit known, input t_lat_stats typed_stats);
        int unsigned gap;
        t_lat_stats  predicted;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_latency  <= lat;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_window_txn(mode, lat);
        pending_stats.push_back(known ? typed_stats : predicted);
    endtask

    task automatic check_field(input string field, input logic [LAT_W-1:0] want,
                               input logic [LAT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%h actual 0x%h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // result monitor: every accepted result against the oldest booked statistics
    always @(posedge i_clk) begin
        t_lat_stats want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: result with nothing expected, min 0x%h max 0x%h fill %0d",
                         $time, o_min_latency, o_max_latency, o_fill_count);
                mismatch_count++;
            end else begin
                want = pending_stats.pop_front();
                check_field("min_latency",  want.min_lat,  o_min_latency);
                check_field("max_latency",  want.max_lat,  o_max_latency);
                check_field("mean_latency", want.mean_lat, o_mean_latency);
                check_field("jitter",       want.jitter,   o_jitter);
                check_field("fill_count",   LAT_W'(want.fill), LAT_W'(o_fill_count));
            end
        end
    end

    // result sink: random stalls, plus one long hold-off on request so the core backs up
    initial begin : result_sink
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD_CYCLES;
            end else begin
                gap = idle_gap();
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // stimulus: reset, directed table, then random blocks
    initial begin : stimulus
        t_stim_row    row;
        int unsigned  sent;
        int unsigned  block_len;
        int unsigned  clear_odds;
        int unsigned  j;
        int unsigned  k;
        t_lat_profile profile;
        logic         mode;
        sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            row = directed_rows[k];
            send_window_txn(row.mode, row.latency, row.known, row.stats);
        end

        // random blocks; clear_odds of zero means the block never clears, so the window wraps
        while (sent < RANDOM_ITEMS) begin
            block_len  = $urandom_range(60, 20);
            burst      = ($urandom_range(3) == 0);
            profile    = ($urandom_range(1) == 0) ? LAT_ANY
                                                  : t_lat_profile'($urandom_range(LAT_ONEHOT));
            clear_odds = ($urandom_range(2) == 0) ? 0 : 24;
            for (j = 0; j < block_len && sent < RANDOM_ITEMS; j++) begin
                if (sent == LONG_HOLD_AT) begin
                    // keep offering back to back while the sink sits on a result
                    long_hold_req = 1'b1;
                    burst         = 1'b1;
                end
                if (sent == SENDER_PAUSE_AT) begin
                    // sender goes quiet until every owed result is out
                    i_in_valid <= 1'b0;
                    while (pending_stats.size() != 0) @(posedge i_clk);
                end
                mode = (clear_odds != 0 && $urandom_range(clear_odds) == 0) ? MODE_CLEAR
                                                                              : MODE_ADD;
                send_window_txn(mode, draw_latency(profile), 1'b0, '0);
                sent++;
            end
        end
        i_in_valid <= 1'b0;
        burst = 1'b0;

        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
sv/swls_pkg.sv
sv/sliding_window_latency_stats_core.sv
verif/sliding_window_latency_stats_core_tb.sv
